[sv/mkd_pkg.sv]
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types and constants of the multi-key debouncer with press latch.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int unsigned KeyCount     = 4;
  localparam int unsigned PinBits      = 4;
  localparam int unsigned FieldW       = 4;
  localparam int unsigned LimitW       = 4;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 4;
  localparam logic [LimitW-1:0] LimitAtReset = LimitW'(10);

  typedef enum logic [1:0] {
    ReqSample     = 2'd0,
    ReqRead       = 2'd1,
    ReqSampleRead = 2'd2
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounceLimit = 2'd0,
    CfgSingleShot    = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [PinBits-1:0] pin_levels;
  } mkd_in_t;

  typedef struct packed {
    logic [FieldW-1:0] key_value;
    logic [FieldW-1:0] stable_levels;
    logic [FieldW-1:0] pending_events;
  } mkd_out_t;

  // Controls broadcast to every key cell.
  typedef struct packed {
    logic              sample_en;
    logic              read_en;
    logic              single_shot;
    logic [LimitW-1:0] limit;
  } mkd_ctrl_t;

  // What each key cell reports after the beat.
  typedef struct packed {
    logic stable;
    logic pending;
    logic hit;
  } mkd_stat_t;

endpackage

[sv/mkd_key_cell.sv]
// ----------------------------------------------------------------------------
// mkd_key_cell
// One key: stable level, debounce counter and press flag. Read priority
// ripples through the row as a taken flag from the lower key.
// ----------------------------------------------------------------------------
module mkd_key_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mkd_pkg::mkd_ctrl_t ctrl_i,
  input  logic              raw_i,
  input  logic              taken_i,
  output logic              taken_o,
  output mkd_pkg::mkd_stat_t stat_o
);
  import mkd_pkg::*;

  logic              stable_q, stable_d;
  logic              pending_q, pending_d;
  logic [LimitW-1:0] count_q, count_d;
  logic              smp_stable, smp_pending;
  logic              eligible, hit;

  always_comb begin
    smp_stable  = stable_q;
    smp_pending = pending_q;
    count_d     = count_q;
    if (ctrl_i.sample_en) begin
      if (raw_i != stable_q) begin
        if (count_q < ctrl_i.limit) begin
          count_d = count_q + LimitW'(1);
        end else begin
          // confirm the new level, latch a press on a fall
          smp_stable = raw_i;
          if (!raw_i) begin
            smp_pending = 1'b1;
          end
        end
      end else begin
        count_d = '0;
      end
    end
    eligible  = smp_pending && !(ctrl_i.single_shot && !smp_stable);
    hit       = ctrl_i.read_en && eligible && !taken_i;
    pending_d = smp_pending && !hit;
    stable_d  = smp_stable;
  end

  assign taken_o        = taken_i || hit;
  assign stat_o.stable  = stable_d;
  assign stat_o.pending = pending_d;
  assign stat_o.hit     = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= 1'b1;
      pending_q <= 1'b0;
      count_q   <= '0;
    end else begin
      stable_q  <= stable_d;
      pending_q <= pending_d;
      count_q   <= count_d;
    end
  end

endmodule

[sv/multi_key_debounce_event_latch.sv]
// ----------------------------------------------------------------------------
// multi_key_debounce_event_latch
// Debounces a row of active-low keys and latches press events for readout.
// Output register: the result beat follows in the cycle after the input beat.
// Throughput: 1 item per cycle unless an untaken result stalls the input; the
//   key row updates all keys and ripples read priority in the same cycle.
// Reset: levels released, counters and events cleared, limit 10, single-shot
//   off; no clearing pass, items are taken right after reset.
// ----------------------------------------------------------------------------
module multi_key_debounce_event_latch (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mkd_pkg::mkd_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mkd_pkg::mkd_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mkd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mkd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import mkd_pkg::*;

  logic [LimitW-1:0] limit_q, limit_d;
  logic              single_shot_q, single_shot_d;
  logic              out_valid_q, out_valid_d;
  mkd_out_t          out_data_q, out_data_d;

  logic              in_fire;
  mkd_ctrl_t         ctrl;
  logic [KeyCount-1:0] raw;
  logic [KeyCount:0]   taken;
  mkd_stat_t [KeyCount-1:0] stat;
  logic [KeyCount-1:0] hit_vec, stable_vec, pending_vec;

  // Config writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    limit_d       = limit_q;
    single_shot_d = single_shot_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDebounceLimit: limit_d       = cfg_data_i[LimitW-1:0];
        CfgSingleShot:    single_shot_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input beat and request decode
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    ctrl.sample_en   = 1'b0;
    ctrl.read_en     = 1'b0;
    ctrl.single_shot = single_shot_q;
    ctrl.limit       = limit_q;
    if (in_fire) begin
      unique case (in_data_i.req_type)
        ReqSample:     ctrl.sample_en = 1'b1;
        ReqRead:       ctrl.read_en   = 1'b1;
        ReqSampleRead: begin
          ctrl.sample_en = 1'b1;
          ctrl.read_en   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Key row
  assign taken[0] = 1'b0;

  for (genvar k = 0; k < KeyCount; k++) begin : g_key
    if (k < PinBits) begin : g_pin
      assign raw[k] = in_data_i.pin_levels[k];
    end else begin : g_nopin
      assign raw[k] = 1'b1;
    end

    mkd_key_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .raw_i   (raw[k]),
      .taken_i (taken[k]),
      .taken_o (taken[k+1]),
      .stat_o  (stat[k])
    );

    assign hit_vec[k]     = stat[k].hit;
    assign stable_vec[k]  = stat[k].stable;
    assign pending_vec[k] = stat[k].pending;
  end

  // Pack result fields, drop keys beyond the field width
  for (genvar b = 0; b < FieldW; b++) begin : g_pack
    if (b < KeyCount) begin : g_key_bit
      assign out_data_d.key_value[b]      = hit_vec[b];
      assign out_data_d.stable_levels[b]  = stable_vec[b];
      assign out_data_d.pending_events[b] = pending_vec[b];
    end else begin : g_pad
      assign out_data_d.key_value[b]      = 1'b0;
      assign out_data_d.stable_levels[b]  = 1'b0;
      assign out_data_d.pending_events[b] = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q       <= LimitAtReset;
      single_shot_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      limit_q       <= limit_d;
      single_shot_q <= single_shot_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  // Assertions
  a_one_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one key reported in one beat");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted beat produced no result");

  a_reported_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_data_q.key_value & out_data_q.pending_events) == '0))
    else $error("reported key still pending");

  // without a sample the row shows the levels it latched at the last edge
  a_levels_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl.sample_en |-> $stable(stable_vec))
    else $error("stable level moved without a sample");

endmodule
